// ===== sv/mpct_pkg.sv =====
// Shared constants and helpers for the mouse packet cursor tracker.
package mpct_pkg;

  localparam int unsigned PKT_BYTES = 3;
  localparam int unsigned IDX_W     = $clog2(PKT_BYTES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PKT_BYTES - 1);

  localparam int unsigned POS_W  = 12;
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned DLT_W  = 16;
  localparam int unsigned BTN_W  = 3;

  localparam logic ACT_BYTE   = 1'b0;
  localparam logic ACT_INJECT = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [POS_W-1:0] LIM_X_RST = 12'd1023;
  localparam logic [POS_W-1:0] LIM_Y_RST = 12'd767;

  // Largest legal coordinate for a given screen size.
  function automatic logic [POS_W-1:0] limit_of(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] m1;
    begin
      m1 = size - SIZE_W'(1);
      if (size == '0) begin
        limit_of = '0;
      end else if (size > SIZE_W'(4096)) begin
        limit_of = '1;
      end else begin
        limit_of = m1[POS_W-1:0];
      end
    end
  endfunction

endpackage

// ===== sv/mpct_axis_clamp.sv =====
// One cursor axis: apply a signed delta, optionally negated, and clamp to 0..limit.
module mpct_axis_clamp
  import mpct_pkg::*;
(
  input  logic [POS_W-1:0]        pos,
  input  logic signed [DLT_W-1:0] delta,
  input  logic                    negate,
  input  logic [POS_W-1:0]        limit,
  output logic [POS_W-1:0]        pos_new
);

  localparam int unsigned SUM_W = DLT_W + 2;

  logic signed [SUM_W-1:0] dlt_ext;
  logic signed [SUM_W-1:0] sum;

  assign dlt_ext = negate ? -SUM_W'(delta) : SUM_W'(delta);
  assign sum     = $signed({{(SUM_W-POS_W){1'b0}}, pos}) + dlt_ext;

  always_comb begin
    if (sum[SUM_W-1]) begin
      pos_new = '0;
    end else if (sum[SUM_W-2:0] > {{(SUM_W-1-POS_W){1'b0}}, limit}) begin
      pos_new = limit;
    end else begin
      pos_new = sum[POS_W-1:0];
    end
  end

endmodule

// ===== sv/mouse_packet_cursor_tracker.sv =====
// Stage 1 moves an accepted request from the input to the result register. One
// request per cycle while out_ready is high; a stall holds at most two requests
// (input and result registers), after which in_ready drops until out_ready returns.
// Every third mouse byte and every injected move give one result; other bytes none.
// Reset (rst_n low, synchronous): cursor 0,0, packet restarts,
// screen limits return to 1024 x 768.
module mouse_packet_cursor_tracker
  import mpct_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [SIZE_W-1:0]       cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_action,
  input  logic [7:0]              in_data_byte,
  input  logic signed [DLT_W-1:0] in_inject_dx,
  input  logic signed [DLT_W-1:0] in_inject_dy,
  input  logic [BTN_W-1:0]        in_inject_buttons,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [POS_W-1:0]        out_cursor_x,
  output logic [POS_W-1:0]        out_cursor_y,
  output logic [BTN_W-1:0]        out_button_state
);

  logic [POS_W-1:0] lim_x_r, lim_y_r;

  logic                    s1_valid_r;
  logic                    s1_action_r;
  logic [7:0]              s1_byte_r;
  logic signed [DLT_W-1:0] s1_dx_r, s1_dy_r;
  logic [BTN_W-1:0]        s1_btn_r;

  logic [IDX_W-1:0] byte_idx_r, byte_idx_nxt;
  logic [7:0]       pkt0_r, pkt1_r;
  logic [POS_W-1:0] pos_x_r, pos_y_r;

  logic             out_valid_r;
  logic [POS_W-1:0] out_x_r, out_y_r;
  logic [BTN_W-1:0] out_btn_r;

  logic                    s1_adv, is_inj, has_res;
  logic signed [DLT_W-1:0] dx, dy;
  logic [BTN_W-1:0]        btn_new;
  logic [POS_W-1:0]        x_new, y_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_x_r <= LIM_X_RST;
      lim_y_r <= LIM_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  lim_x_r <= limit_of(cfg_wdata);
        CFG_HEIGHT: lim_y_r <= limit_of(cfg_wdata);
        default:    ;
      endcase
    end
  end

  // stage 1 moves on when the result register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_data_byte;
      s1_dx_r     <= in_inject_dx;
      s1_dy_r     <= in_inject_dy;
      s1_btn_r    <= in_inject_buttons;
    end
  end

  assign is_inj  = (s1_action_r == ACT_INJECT);
  assign has_res = is_inj || (byte_idx_r == IDX_LAST);
  assign dx      = is_inj ? s1_dx_r : DLT_W'($signed(pkt1_r));
  assign dy      = is_inj ? s1_dy_r : DLT_W'($signed(s1_byte_r));
  assign btn_new = is_inj ? s1_btn_r : pkt0_r[BTN_W-1:0];

  always_comb begin
    byte_idx_nxt = byte_idx_r;
    if (!is_inj) begin
      byte_idx_nxt = (byte_idx_r == IDX_LAST) ? '0 : byte_idx_r + IDX_W'(1);
    end
  end

  mpct_axis_clamp u_clamp_x (
    .pos     (pos_x_r),
    .delta   (dx),
    .negate  (1'b0),
    .limit   (lim_x_r),
    .pos_new (x_new)
  );

  // positive dy moves up, toward row 0
  mpct_axis_clamp u_clamp_y (
    .pos     (pos_y_r),
    .delta   (dy),
    .negate  (1'b1),
    .limit   (lim_y_r),
    .pos_new (y_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r <= '0;
      pos_x_r    <= '0;
      pos_y_r    <= '0;
    end else if (s1_adv) begin
      byte_idx_r <= byte_idx_nxt;
      if (has_res) begin
        pos_x_r <= x_new;
        pos_y_r <= y_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && !is_inj) begin
      if (byte_idx_r == '0) begin
        pkt0_r <= s1_byte_r;
      end
      if (byte_idx_r == IDX_W'(1)) begin
        pkt1_r <= s1_byte_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= has_res;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && has_res) begin
      out_x_r   <= x_new;
      out_y_r   <= y_new;
      out_btn_r <= btn_new;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cursor_x     = out_x_r;
  assign out_cursor_y     = out_y_r;
  assign out_button_state = out_btn_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r <= IDX_LAST)
    else $error("packet byte index out of range");

  a_x_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && has_res) |=> (out_cursor_x <= $past(lim_x_r)))
    else $error("cursor x beyond screen limit");

  a_y_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && has_res) |=> (out_cursor_y <= $past(lim_y_r)))
    else $error("cursor y beyond screen limit");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("request accepted while pipeline is stalled");

endmodule
